// ===== rtl/core/pli_pkg.sv =====
// Shared types and constants of the piecewise linear interpolator.
// Holds the controller state encoding and the command and status records.
// No dependencies.
package pli_pkg;

    // Table geometry and field widths
    localparam int DEF_MAX_POINTS = 64;
    localparam int FIELD_W        = 24;
    localparam int COUNT_W        = 7;
    localparam int IDX_W          = 6;
    localparam int PROD_W         = 2 * FIELD_W;

    // Divider step count: one quotient bit per step
    localparam int DIV_STEPS = FIELD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Configuration port
    localparam int  APB_ADDR_W      = 3;
    localparam int  APB_DATA_W      = 32;
    localparam logic REG_POINT_COUNT = 1'b0;

    // Opcodes carried in tuser
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_CHECK,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_FIN,
        ST_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic start;
        logic rd_en;
        logic eval;
        logic first;
        logic mul;
        logic div_start;
        logic finish;
        logic push;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic hit;
        logic seg;
        logic div_busy;
    } status_t;

endpackage

// ===== rtl/core/pli_div.sv =====
// Restoring divider, one quotient bit per cycle, 48-bit dividend by 24-bit divisor.
// The dividend must satisfy dividend < divisor * 2^24 so the quotient fits 24 bits.
// Depends on pli_pkg.
module pli_div import pli_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [PROD_W-1:0]  dividend,
    input  logic [FIELD_W-1:0] divisor,
    output logic               busy,
    output logic [FIELD_W-1:0] quotient,
    output logic [FIELD_W-1:0] remainder
);

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [FIELD_W-1:0]   rem_reg;
    logic [FIELD_W-1:0]   lo_reg;

    logic [FIELD_W:0]     trial;
    logic                 fits;
    logic [FIELD_W-1:0]   rem_next;

    // Shift in the next dividend bit and try the subtraction
    always_comb begin
        trial    = {rem_reg, lo_reg[FIELD_W-1]};
        fits     = trial >= {1'b0, divisor};
        rem_next = fits ? FIELD_W'(trial - {1'b0, divisor}) : trial[FIELD_W-1:0];
    end

    // Step counter and busy flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Partial remainder and quotient shift register
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend[PROD_W-1:FIELD_W];
            lo_reg  <= dividend[FIELD_W-1:0];
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            lo_reg  <= {lo_reg[FIELD_W-2:0], fits};
        end
    end

    assign busy      = busy_reg;
    assign quotient  = lo_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/core/pli_dp.sv =====
// Datapath: breakpoint memory, scan compare, candidate capture, multiply and divide.
// Acts on the command record from pli_ctrl and reports a status record.
// Depends on pli_pkg and pli_div.
module pli_dp import pli_pkg::*; #(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int AW         = $clog2(MAX_POINTS)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cmd_t               cmd,
    input  logic [AW-1:0]      rd_addr,
    input  logic [IDX_W-1:0]   wr_idx,
    input  logic [FIELD_W-1:0] wr_x,
    input  logic [FIELD_W-1:0] wr_y,
    input  logic [FIELD_W-1:0] query_x,
    output status_t            st,
    output logic [FIELD_W-1:0] res_value,
    output logic               res_found
);

    // Breakpoint memory, x in the upper half, y in the lower half
    logic [PROD_W-1:0]  point_mem [MAX_POINTS];
    logic [FIELD_W-1:0] rd_x_reg;
    logic [FIELD_W-1:0] rd_y_reg;

    logic [FIELD_W-1:0] q_reg;
    logic [FIELD_W-1:0] prev_x_reg;
    logic [FIELD_W-1:0] prev_y_reg;
    logic               hit_reg;
    logic               seg_reg;
    logic               neg_reg;
    logic [FIELD_W-1:0] y0_reg;
    logic [FIELD_W-1:0] dx_reg;
    logic [FIELD_W-1:0] t_reg;
    logic [FIELD_W-1:0] dy_reg;
    logic [PROD_W-1:0]  mag_reg;
    logic [FIELD_W-1:0] seg_val_reg;

    logic               seg_hit;
    logic               eq_hit;
    logic               div_busy;
    logic [FIELD_W-1:0] quo;
    logic [FIELD_W-1:0] rem;
    logic [FIELD_W-1:0] quo_adj;

    // Write a breakpoint on load, drop slots beyond the table
    always_ff @(posedge aclk) begin
        if (cmd.load && (32'(wr_idx) < 32'(MAX_POINTS))) begin
            point_mem[AW'(wr_idx)] <= {wr_x, wr_y};
        end
    end

    // Registered read for the scan
    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            {rd_x_reg, rd_y_reg} <= point_mem[rd_addr];
        end
    end

    // Segment and exact-match tests against the entry just read
    always_comb begin
        seg_hit = !cmd.first && (q_reg > prev_x_reg) && (q_reg < rd_x_reg);
        eq_hit  = q_reg == rd_x_reg;
    end

    // Candidate flags: the latest match in scan order wins
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
            seg_reg <= 1'b0;
        end else if (cmd.start) begin
            hit_reg <= 1'b0;
            seg_reg <= 1'b0;
        end else if (cmd.eval && (eq_hit || seg_hit)) begin
            hit_reg <= 1'b1;
            seg_reg <= !eq_hit;
        end
    end

    // Capture query, previous entry and segment operands
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            q_reg <= query_x;
        end
        if (cmd.eval) begin
            prev_x_reg <= rd_x_reg;
            prev_y_reg <= rd_y_reg;
            if (eq_hit) begin
                y0_reg <= rd_y_reg;
            end else if (seg_hit) begin
                y0_reg  <= prev_y_reg;
                dx_reg  <= rd_x_reg - prev_x_reg;
                t_reg   <= q_reg - prev_x_reg;
                neg_reg <= rd_y_reg < prev_y_reg;
                dy_reg  <= (rd_y_reg < prev_y_reg) ? prev_y_reg - rd_y_reg
                                                   : rd_y_reg - prev_y_reg;
            end
        end
        if (cmd.mul) begin
            mag_reg <= PROD_W'(dy_reg) * PROD_W'(t_reg);
        end
        if (cmd.finish) begin
            seg_val_reg <= neg_reg ? y0_reg - quo_adj : y0_reg + quo_adj;
        end
    end

    pli_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (mag_reg),
        .divisor   (dx_reg),
        .busy      (div_busy),
        .quotient  (quo),
        .remainder (rem)
    );

    // Round a falling segment toward minus infinity
    assign quo_adj = quo + FIELD_W'(neg_reg && (rem != '0));

    assign st.hit      = hit_reg;
    assign st.seg      = seg_reg;
    assign st.div_busy = div_busy;

    assign res_found = hit_reg;
    assign res_value = hit_reg ? (seg_reg ? seg_val_reg : y0_reg) : '0;

endmodule

// ===== rtl/core/pli_ctrl.sv =====
// Controller: takes items, sequences the table scan, the multiply and the divide.
// Drives the command record to pli_dp and reads back its status record.
// Depends on pli_pkg.
module pli_ctrl import pli_pkg::*; #(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int AW         = $clog2(MAX_POINTS),
    parameter int CW         = $clog2(MAX_POINTS + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_op,
    input  logic [COUNT_W-1:0] point_count,
    input  logic               out_free,
    input  status_t            st,
    output logic               s_ready,
    output cmd_t               cmd,
    output logic [AW-1:0]      rd_addr
);

    state_t        state_reg,  state_next;
    logic [AW-1:0] idx_reg,    idx_next;
    logic [AW-1:0] last_reg,   last_next;
    logic          eval_reg,   eval_next;
    logic          first_reg,  first_next;
    logic [CW-1:0] n_used;

    // Clamp the point count to the table depth
    always_comb begin
        if (32'(point_count) > 32'(MAX_POINTS)) begin
            n_used = CW'(MAX_POINTS);
        end else begin
            n_used = CW'(point_count);
        end
    end

    // State and scan registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            last_reg  <= '0;
            eval_reg  <= 1'b0;
            first_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            last_reg  <= last_next;
            eval_reg  <= eval_next;
            first_reg <= first_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        last_next     = last_reg;
        eval_next     = 1'b0;
        first_next    = 1'b0;
        s_ready       = 1'b0;
        cmd           = '0;
        cmd.eval      = eval_reg;
        cmd.first     = first_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_op == OP_LOAD) begin
                        cmd.load = 1'b1;
                    end else begin
                        cmd.start = 1'b1;
                        idx_next  = '0;
                        last_next = AW'(n_used - CW'(1));
                        state_next = (n_used == '0) ? ST_DONE : ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // Read one entry per cycle, evaluate it the cycle after
                cmd.rd_en  = 1'b1;
                eval_next  = 1'b1;
                first_next = idx_reg == '0;
                idx_next   = idx_reg + AW'(1);
                if (idx_reg == last_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                cmd.mul = 1'b1;
                state_next = (st.hit && st.seg) ? ST_DIV_START : ST_DONE;
            end
            ST_DIV_START: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (!st.div_busy) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                cmd.finish = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // Hold until the output register can take the result
                if (out_free) begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rd_addr = idx_reg;

endmodule

// ===== rtl/core/piecewise_linear_interpolator.sv =====
// Piecewise linear interpolator: top level with stream ports and APB register.
// Query over the n points in use: a memory scan of one entry per cycle, then for a segment
// the 24-step divider; an exact hit or a miss skips the divide, and n at 0 skips the scan.
// One item is worked on at a time.
// A finished result waits in the output register while the next item is taken.
// Synchronous active-low reset clears control state and point_count; the table is not cleared.
module piecewise_linear_interpolator import pli_pkg::*; #(
    parameter int MAX_POINTS = DEF_MAX_POINTS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [79:0]           s_tdata,  // point_index[5:0], point_x[29:6],
                                            // point_y[53:30], query_x[77:54], zero
    input  logic                  s_tuser,  // op
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,  // value[23:0]
    output logic                  m_tuser,  // found
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    logic [COUNT_W-1:0] count_reg;
    logic               m_valid_reg;
    logic [FIELD_W-1:0] m_value_reg;
    logic               m_found_reg;

    cmd_t               cmd;
    status_t            st;
    logic [AW-1:0]      rd_addr;
    logic [FIELD_W-1:0] res_value;
    logic               res_found;
    logic               out_free;

    // Register write and readback
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (psel && penable && pwrite && (paddr[2] == REG_POINT_COUNT)) begin
            count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_POINT_COUNT) ? APB_DATA_W'(count_reg) : '0;

    pli_ctrl #(
        .MAX_POINTS (MAX_POINTS),
        .AW         (AW),
        .CW         (CW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_tvalid),
        .s_op        (s_tuser),
        .point_count (count_reg),
        .out_free    (out_free),
        .st          (st),
        .s_ready     (s_tready),
        .cmd         (cmd),
        .rd_addr     (rd_addr)
    );

    pli_dp #(
        .MAX_POINTS (MAX_POINTS),
        .AW         (AW)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .wr_idx    (s_tdata[5:0]),
        .wr_x      (s_tdata[29:6]),
        .wr_y      (s_tdata[53:30]),
        .query_x   (s_tdata[77:54]),
        .st        (st),
        .res_value (res_value),
        .res_found (res_found)
    );

    // Output register: load a result, drop it once the transfer completes
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.push) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            m_value_reg <= res_value;
            m_found_reg <= res_found;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = m_found_reg;

    // A result is only loaded into a free output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> (!m_valid_reg || m_tready))
        else $error("result loaded over a pending transfer");

    // No item is taken while the divider is running
    assert property (@(posedge aclk) disable iff (!aresetn)
        st.div_busy |-> !s_tready)
        else $error("input taken during division");

    // A miss always reports a zero value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser || (m_tdata == '0)))
        else $error("nonzero value on a miss");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the piecewise linear interpolator.
// Loads breakpoint tables, sets point_count over APB and checks every query result
// against an in-bench predictor or a fixed expected value. Depends on pli_pkg and piecewise_linear_interpolator.
module testbench;
    import pli_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MAX_PTS      = DEF_MAX_POINTS;
    localparam int          REG_SPARE    = 1;          // unmapped register index
    localparam int unsigned RANDOM_ITEMS = 1000;
    localparam int unsigned DRAIN_CYCLES = 128;        // longer than a 64-point segment query
    localparam int unsigned HOLD_AT      = 700;
    localparam int unsigned HOLD_CYCLES  = 500;
    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int          DIR_ROWS     = 23;
    localparam logic [FIELD_W-1:0] FIELD_MAX = '1;

    typedef enum {ROW_LOAD, ROW_QUERY, ROW_REG} row_kind_t;
    typedef enum {ORDER_STRICT, ORDER_DUP, ORDER_TIGHT, ORDER_SHUFFLED} order_t;

    typedef struct packed {
        logic [FIELD_W-1:0] value;
        logic               found;
    } result_t;

    // ROW_REG rows carry the register index in idx and the written value in q
    typedef struct {
        row_kind_t          kind;
        logic [IDX_W-1:0]   idx;
        logic [FIELD_W-1:0] x;
        logic [FIELD_W-1:0] y;
        logic [FIELD_W-1:0] q;
        logic               fixed;
        logic [FIELD_W-1:0] exp_value;
        logic               exp_found;
    } dir_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [79:0]           s_tdata;   // point_index[5:0], point_x[29:6],
                                      // point_y[53:30], query_x[77:54], zero
    logic                  s_tuser;   // op
    logic                  m_tvalid;
    logic                  m_tready;
    logic [23:0]           m_tdata;   // value[23:0]
    logic                  m_tuser;   // found
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Shadow state of the block
    logic [FIELD_W-1:0] shadow_x [MAX_PTS];
    logic [FIELD_W-1:0] shadow_y [MAX_PTS];
    logic [COUNT_W-1:0] shadow_count;

    result_t     pending_results [$];
    dir_row_t    directed_rows [DIR_ROWS];
    int unsigned items_done;
    int unsigned error_count;
    int unsigned cycle_count;
    bit          hold_req;

    piecewise_linear_interpolator #(
        .MAX_POINTS(DEF_MAX_POINTS)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // Idle rates: sender light / receiver heavy, then swapped, then none
    function automatic int unsigned tx_idle_pct();
        if (items_done < 350) return 35;
        if (items_done < HOLD_AT) return 53;
        return 0;
    endfunction

    function automatic int unsigned rx_idle_pct();
        if (items_done < 350) return 53;
        if (items_done < HOLD_AT) return 35;
        return 0;
    endfunction

    // Straight-line value between two points, floored toward minus infinity
    function automatic logic [FIELD_W-1:0] segment_value(input logic [FIELD_W-1:0] x0,
                                                         input logic [FIELD_W-1:0] y0,
                                                         input logic [FIELD_W-1:0] x1,
                                                         input logic [FIELD_W-1:0] y1,
                                                         input logic [FIELD_W-1:0] q);
        logic [63:0] span;
        logic [63:0] run;
        logic [63:0] prod;
        logic [63:0] quot;
        span = 64'(x1) - 64'(x0);
        run  = 64'(q) - 64'(x0);
        if (y1 >= y0) begin
            prod = (64'(y1) - 64'(y0)) * run;
            quot = prod / span;
            return y0 + quot[FIELD_W-1:0];
        end else begin
            prod = (64'(y0) - 64'(y1)) * run;
            quot = (prod + span - 64'd1) / span;
            return y0 - quot[FIELD_W-1:0];
        end
    endfunction

    // Scan the points in use; segment test before equality, last candidate wins
    function automatic result_t interpolate_at(input logic [FIELD_W-1:0] q);
        result_t     res;
        int unsigned lim;
        int unsigned i;
        res = '0;
        lim = (shadow_count > MAX_PTS) ? MAX_PTS : shadow_count;
        for (i = 0; i < lim; i++) begin
            if (i + 1 < lim && q > shadow_x[i] && q < shadow_x[i+1]) begin
                res.value = segment_value(shadow_x[i], shadow_y[i],
                                          shadow_x[i+1], shadow_y[i+1], q);
                res.found = 1'b1;
            end
            if (q == shadow_x[i]) begin
                res.value = shadow_y[i];
                res.found = 1'b1;
            end
        end
        return res;
    endfunction

    // Offer one item, wait for the transfer, then update the shadow state
    task automatic send_item(input logic op, input logic [IDX_W-1:0] idx,
                             input logic [FIELD_W-1:0] px, input logic [FIELD_W-1:0] py,
                             input logic [FIELD_W-1:0] q, input logic fixed = 1'b0,
                             input logic [FIELD_W-1:0] fixed_value = '0,
                             input logic fixed_found = 1'b0);
        result_t res;
        bit      idled;
        idled = 1'b0;
        while ($urandom_range(0, 99) < tx_idle_pct()) begin
            if (!idled) s_tvalid <= 1'b0;
            idled = 1'b1;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, q, py, px, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_done++;
        if (items_done == HOLD_AT) hold_req = 1'b1;
        if (op == OP_LOAD) begin
            shadow_x[idx] = px;
            shadow_y[idx] = py;
        end else begin
            if (fixed) res = '{fixed_value, fixed_found};
            else res = interpolate_at(q);
            pending_results.insert(pending_results.size(), res);
        end
    endtask

    // Drop valid and wait until the block has nothing left in flight
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // APB write: setup cycle, then access cycle until pready, then back to idle
    task automatic write_reg(input int unsigned reg_idx, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * reg_idx);
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_POINT_COUNT) shadow_count = data[COUNT_W-1:0];
        @(posedge aclk);
    endtask

    // Pick a query aimed at the points in use, with some misses and noise
    function automatic logic [FIELD_W-1:0] pick_query(input int unsigned lim);
        int unsigned r;
        int unsigned i;
        int unsigned lo;
        int unsigned hi;
        r = $urandom_range(0, 99);
        if (lim == 0 || r >= 85) return FIELD_W'($urandom);
        if (r < 30) return shadow_x[$urandom_range(0, lim - 1)];
        if (r < 70 && lim >= 2) begin
            i  = $urandom_range(0, lim - 2);
            lo = shadow_x[i];
            hi = shadow_x[i+1];
            if (hi > lo + 1) return FIELD_W'($urandom_range(lo + 1, hi - 1));
            return FIELD_W'(lo);
        end
        if (r < 80) begin
            if ($urandom_range(0, 1)) return shadow_x[0] - 1'b1;
            return shadow_x[lim-1] + 1'b1;
        end
        return $urandom_range(0, 1) ? FIELD_MAX : '0;
    endfunction

    // One phase: fresh table, idle point_count write, then queries mixed with loads
    task automatic run_phase();
        int unsigned        n;
        int unsigned        r;
        int unsigned        max_step;
        int unsigned        xacc;
        int unsigned        lim;
        int unsigned        nq;
        int unsigned        i;
        int unsigned        k;
        int unsigned        lo;
        int unsigned        hi;
        order_t             order;
        logic [FIELD_W-1:0] py;
        logic [COUNT_W-1:0] cnt;
        r = $urandom_range(0, 9);
        if (r < 7) n = $urandom_range(2, 12);
        else if (r < 9) n = $urandom_range(13, MAX_PTS - 1);
        else n = MAX_PTS;
        r = $urandom_range(0, 7);
        if (r < 5) order = ORDER_STRICT;
        else if (r == 5) order = ORDER_DUP;
        else if (r == 6) order = ORDER_TIGHT;
        else order = ORDER_SHUFFLED;
        max_step = FIELD_MAX / n;

        // Load the table
        for (i = 0; i < n; i++) begin
            if (i == 0) begin
                if (order == ORDER_TIGHT) xacc = $urandom_range(0, FIELD_MAX - 4 * n);
                else xacc = $urandom_range(0, max_step);
            end else begin
                case (order)
                    ORDER_STRICT: xacc = xacc + $urandom_range(1, max_step);
                    ORDER_DUP: begin
                        if ($urandom_range(0, 2) != 0) xacc = xacc + $urandom_range(0, max_step);
                    end
                    ORDER_TIGHT: xacc = xacc + $urandom_range(1, 3);
                    default: xacc = $urandom;
                endcase
            end
            if ($urandom_range(0, 15) == 0) py = $urandom_range(0, 1) ? FIELD_MAX : '0;
            else py = FIELD_W'($urandom);
            send_item(OP_LOAD, IDX_W'(i), FIELD_W'(xacc), py, FIELD_W'($urandom));
        end

        // Set point_count while idle; counts above the table size clamp
        settle();
        if (n == MAX_PTS) begin
            case ($urandom_range(0, 3))
                0: cnt = COUNT_W'(MAX_PTS);
                1: cnt = COUNT_W'(MAX_PTS + 1);
                2: cnt = '1;
                default: cnt = COUNT_W'($urandom_range(MAX_PTS + 1, 126));
            endcase
        end else if ($urandom_range(0, 9) == 0) begin
            cnt = COUNT_W'($urandom_range(0, 1));
        end else begin
            cnt = COUNT_W'(n);
        end
        if ($urandom_range(0, 7) == 0) write_reg(REG_SPARE, $urandom);
        write_reg(REG_POINT_COUNT, APB_DATA_W'({$urandom, cnt}));
        lim = (shadow_count > MAX_PTS) ? MAX_PTS : shadow_count;

        // Queries, with table rewrites and stray loads mixed in
        nq = $urandom_range(8, 40);
        for (k = 0; k < nq; k++) begin
            r = $urandom_range(0, 99);
            if (r < 8 && lim > 0) begin
                i  = $urandom_range(0, lim - 1);
                lo = (i > 0) ? shadow_x[i-1] : 0;
                hi = (i + 1 < lim) ? shadow_x[i+1] : FIELD_MAX;
                if (order == ORDER_SHUFFLED) xacc = $urandom;
                else xacc = $urandom_range(lo, hi);
                send_item(OP_LOAD, IDX_W'(i), FIELD_W'(xacc), FIELD_W'($urandom),
                          FIELD_W'($urandom));
            end else if (r < 10) begin
                send_item(OP_LOAD, IDX_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom),
                          FIELD_W'($urandom));
            end else begin
                send_item(OP_QUERY, IDX_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom),
                          pick_query(lim));
            end
        end
    endtask

    // Receiver: random stalls, plus one long hold-off to back the block up
    always @(posedge aclk) begin : result_sink
        int unsigned hold_left;
        bit          hold_done;
        if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct());
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: value %h found %b", m_tdata, m_tuser);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata !== want.value) begin
                    $error("value: expected %h, got %h", want.value, m_tdata);
                    error_count++;
                end
                if (m_tuser !== want.found) begin
                    $error("found: expected %b, got %b", want.found, m_tuser);
                    error_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned row;
        aresetn      <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= OP_LOAD;
        m_tready     <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        shadow_count = '0;
        items_done   = 0;
        error_count  = 0;
        cycle_count  = 0;
        hold_req     = 1'b0;

        directed_rows = '{
            // empty table after reset: nothing matches
            '{ROW_QUERY, 6'd0,  24'h000000, 24'h000000, 24'h000000, 1'b1, 24'h000000, 1'b0},
            '{ROW_QUERY, 6'd63, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 24'h000000, 1'b0},
            // four points: rise to full scale, fall to zero, rise again
            '{ROW_LOAD,  6'd0,  24'h000000, 24'h000000, 24'hFFFFFF, 1'b0, 24'h0, 1'b0},
            '{ROW_LOAD,  6'd1,  24'h100000, 24'hFFFFFF, 24'h000000, 1'b0, 24'h0, 1'b0},
            '{ROW_LOAD,  6'd2,  24'h200000, 24'h000000, 24'h000000, 1'b0, 24'h0, 1'b0},
            '{ROW_LOAD,  6'd3,  24'hFFFFFF, 24'h123456, 24'h000000, 1'b0, 24'h0, 1'b0},
            '{ROW_LOAD,  6'd63, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 24'h0, 1'b0},
            '{ROW_REG,   6'(REG_POINT_COUNT), 24'h0, 24'h0, 24'd4, 1'b0, 24'h0, 1'b0},
            // exact hits at both ends and in the middle
            '{ROW_QUERY, 6'd5,  24'h0, 24'h0, 24'h000000, 1'b1, 24'h000000, 1'b1},
            '{ROW_QUERY, 6'd5,  24'h0, 24'h0, 24'hFFFFFF, 1'b1, 24'h123456, 1'b1},
            '{ROW_QUERY, 6'd5,  24'h0, 24'h0, 24'h100000, 1'b1, 24'hFFFFFF, 1'b1},
            // rising, falling and edge-adjacent segments
            '{ROW_QUERY, 6'd0,  24'h0, 24'h0, 24'h080000, 1'b0, 24'h0, 1'b0},
            '{ROW_QUERY, 6'd0,  24'h0, 24'h0, 24'h180000, 1'b0, 24'h0, 1'b0},
            '{ROW_QUERY, 6'd0,  24'h0, 24'h0, 24'h100001, 1'b0, 24'h0, 1'b0},
            '{ROW_QUERY, 6'd0,  24'h0, 24'h0, 24'hFFFFFE, 1'b0, 24'h0, 1'b0},
            // fewer points in use: query beyond the last one misses
            '{ROW_REG,   6'(REG_POINT_COUNT), 24'h0, 24'h0, 24'd2, 1'b0, 24'h0, 1'b0},
            '{ROW_QUERY, 6'd0,  24'h0, 24'h0, 24'h180000, 1'b1, 24'h000000, 1'b0},
            // write to an unmapped register leaves point_count alone
            '{ROW_REG,   6'(REG_SPARE), 24'h0, 24'h0, 24'h00007F, 1'b0, 24'h0, 1'b0},
            '{ROW_QUERY, 6'd0,  24'h0, 24'h0, 24'h100000, 1'b1, 24'hFFFFFF, 1'b1},
            // duplicate abscissa: the later slot wins
            '{ROW_LOAD,  6'd2,  24'h100000, 24'h0ABCDE, 24'h0, 1'b0, 24'h0, 1'b0},
            '{ROW_REG,   6'(REG_POINT_COUNT), 24'h0, 24'h0, 24'd3, 1'b0, 24'h0, 1'b0},
            '{ROW_QUERY, 6'd0,  24'h0, 24'h0, 24'h100000, 1'b1, 24'h0ABCDE, 1'b1},
            '{ROW_QUERY, 6'd0,  24'h0, 24'h0, 24'h0FFFFF, 1'b0, 24'h0, 1'b0}
        };

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table
        for (row = 0; row < DIR_ROWS; row++) begin
            case (directed_rows[row].kind)
                ROW_LOAD: send_item(OP_LOAD, directed_rows[row].idx, directed_rows[row].x,
                                    directed_rows[row].y, directed_rows[row].q);
                ROW_QUERY: send_item(OP_QUERY, directed_rows[row].idx, directed_rows[row].x,
                                     directed_rows[row].y, directed_rows[row].q,
                                     directed_rows[row].fixed, directed_rows[row].exp_value,
                                     directed_rows[row].exp_found);
                default: begin
                    settle();
                    write_reg(directed_rows[row].idx, 32'(directed_rows[row].q));
                end
            endcase
        end

        // Random phases
        while (items_done < RANDOM_ITEMS + DIR_ROWS) run_phase();

        settle();
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
